// ----- sv/lfdc_pkg.sv -----
// Types and constants shared by the line follower drive controller.
package lfdc_pkg;

  // Light sensor reading width
  localparam int SENSOR_BITS = 10;

  localparam int THRESH_W = 11;
  localparam int RT_W     = 20;
  localparam int CMP_W    = (SENSOR_BITS > THRESH_W) ? SENSOR_BITS : THRESH_W;
  localparam int CAL_W    = ((SENSOR_BITS > 10) ? SENSOR_BITS : 10) + 1;

  // Event kinds
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_LIGHT  = 2'd1;
  localparam logic [1:0] ACT_BUTTON = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_LOST_LIMIT   = 2'd0;
  localparam logic [1:0] REG_CALIB_OFFSET = 2'd1;
  localparam logic [1:0] REG_DRIVE_SPEED  = 2'd2;
  localparam logic [1:0] REG_TICK_STEP    = 2'd3;

  // Command priorities
  localparam logic [6:0] PRIO_UNCAL   = 7'd99;
  localparam logic [6:0] PRIO_REST    = 7'd10;
  localparam logic [6:0] PRIO_ON_LINE = 7'd21;
  localparam logic [6:0] PRIO_SEARCH  = 7'd20;
  localparam logic [6:0] PRIO_HOLD    = 7'd19;

  // Headings
  localparam logic [1:0] HEAD_RIGHT    = 2'd0;
  localparam logic [1:0] HEAD_LEFT     = 2'd1;
  localparam logic [1:0] HEAD_STRAIGHT = 2'd3;

  // Durations
  localparam logic [RT_W-1:0] LINE_TIME   = 20'd100;
  localparam logic [RT_W-1:0] TURN_TIME   = 20'd150;
  localparam logic [9:0]      SEARCH_STEP = 10'd1000;
  localparam logic [RT_W:0]   HOLD_EXTRA  = 21'd10;
  localparam logic [RT_W-1:0] RT_MAX      = 20'h7FFFF;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd400;
  localparam logic [7:0]          LOST_FULL    = 8'd255;

  typedef struct packed {
    logic [1:0]             action;
    logic [SENSOR_BITS-1:0] light_sample;
    logic                   touch;
  } evt_word_t;

  typedef struct packed {
    logic              drive_valid;
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
    logic              brake;
    logic [6:0]        out_priority;
    logic [1:0]        out_heading;
    logic [7:0]        out_lost;
  } res_word_t;

endpackage

// ----- sv/line_follower_drive_controller.sv -----
// Line follower drive controller: event register, single-pass update logic, result register.
//
//   channel   direction   handshake             word
//   evt       in          evt_valid/evt_stall   evt_word_t (action, light_sample, touch)
//   res       out         res_valid/res_stall   res_word_t (one word per event)
//   cfg       in          cfg_we                cfg_index, cfg_data
//
// Each event passes through the event register, then the state update and result
// capture in the result register. One event is accepted every cycle while the result
// is not stalled; the state registers are updated as the result word is registered.
// rst is synchronous and restores state, configuration and valid flags to their defaults.
// A stalled result holds the event register, which then stalls evt.
module line_follower_drive_controller
  import lfdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       evt_valid,
  output logic       evt_stall,
  input  evt_word_t  evt,
  output logic       res_valid,
  input  logic       res_stall,
  output res_word_t  res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  // configuration
  logic [3:0] lost_limit;
  logic [9:0] calib_offset;
  logic [6:0] drive_speed;
  logic [7:0] tick_step;

  // event register
  logic      ev_valid;
  evt_word_t ev;
  logic      advance;

  // controller state
  logic [SENSOR_BITS-1:0] previous_light, previous_light_next;
  logic [THRESH_W-1:0]    dark_threshold, dark_threshold_next;
  logic [6:0]             cmd_speed, cmd_speed_next;
  logic signed [RT_W-1:0] remaining_time, remaining_time_next;
  logic [6:0]             cmd_priority, cmd_priority_next;
  logic [1:0]             heading, heading_next;
  logic [1:0]             last_turn, last_turn_next;
  logic [7:0]             lost_count, lost_count_next;

  res_word_t res_next;

  // datapath helpers
  logic [CMP_W-1:0] sample_c, prev_c, thr_c;
  logic             sample_dark, prev_dark, is_lost;
  logic [7:0]       lost_inc, lost_diff;
  logic [17:0]      search_time;
  logic [RT_W:0]    hold_sum;
  logic [RT_W-1:0]  hold_time;
  logic [CAL_W-1:0] cal_sum;
  logic [7:0]       speed8, neg_half8;
  logic             time_left;

  logic [6:0]      prop_prio, prop_speed;
  logic [RT_W-1:0] prop_time;
  logic [1:0]      prop_head, prop_turn;
  logic [7:0]      prop_lost;

  assign advance   = ev_valid && (!res_valid || !res_stall);
  assign evt_stall = ev_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      lost_limit   <= 4'd4;
      calib_offset <= 10'd100;
      drive_speed  <= 7'd50;
      tick_step    <= 8'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOST_LIMIT:   lost_limit   <= cfg_data[3:0];
        REG_CALIB_OFFSET: calib_offset <= cfg_data;
        REG_DRIVE_SPEED:  drive_speed  <= cfg_data[6:0];
        REG_TICK_STEP:    tick_step    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (!evt_stall) begin
      ev_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      ev <= evt;
    end
  end

  // light sample comparisons
  assign sample_c    = CMP_W'(ev.light_sample);
  assign prev_c      = CMP_W'(previous_light);
  assign thr_c       = CMP_W'(dark_threshold);
  assign sample_dark = sample_c < thr_c;
  assign prev_dark   = prev_c < thr_c;
  assign is_lost     = lost_count >= {4'd0, lost_limit};
  assign lost_inc    = (lost_count == LOST_FULL) ? LOST_FULL : lost_count + 8'd1;
  assign lost_diff   = lost_count - {4'd0, lost_limit};
  assign search_time = {10'd0, lost_diff} * {8'd0, SEARCH_STEP};

  // holding proposal extends time, saturating at the positive limit
  assign hold_sum  = {remaining_time[RT_W-1], remaining_time} + HOLD_EXTRA;
  assign hold_time = (!hold_sum[RT_W] && hold_sum[RT_W-1]) ? RT_MAX : hold_sum[RT_W-1:0];

  assign cal_sum = CAL_W'(previous_light) + CAL_W'(calib_offset);

  assign speed8    = {1'b0, cmd_speed};
  assign neg_half8 = 8'd0 - {2'b00, cmd_speed[6:1]};
  assign time_left = !remaining_time[RT_W-1] && (remaining_time != '0);

  always_comb begin
    prop_prio  = PRIO_HOLD;
    prop_speed = cmd_speed;
    prop_time  = hold_time;
    prop_head  = heading;
    prop_turn  = last_turn;
    prop_lost  = lost_count;
    priority if (sample_dark && prev_dark) begin
      prop_prio  = PRIO_ON_LINE;
      prop_speed = drive_speed;
      prop_time  = LINE_TIME;
      prop_head  = HEAD_STRAIGHT;
      prop_lost  = 8'd0;
    end else if (is_lost) begin
      prop_prio  = PRIO_SEARCH;
      prop_speed = drive_speed;
      prop_time  = RT_W'(search_time);
      prop_head  = {1'b0, !heading[0]};
      prop_turn  = {1'b0, !heading[0]};
      prop_lost  = lost_inc;
    end else if (!sample_dark && last_turn == HEAD_LEFT) begin
      prop_prio  = PRIO_SEARCH;
      prop_speed = drive_speed;
      prop_time  = TURN_TIME;
      prop_head  = HEAD_RIGHT;
      prop_turn  = HEAD_RIGHT;
      prop_lost  = lost_inc;
    end else if (!sample_dark && last_turn == HEAD_RIGHT) begin
      prop_prio  = PRIO_SEARCH;
      prop_speed = drive_speed;
      prop_time  = TURN_TIME;
      prop_head  = HEAD_LEFT;
      prop_turn  = HEAD_LEFT;
      prop_lost  = lost_inc;
    end else begin
      prop_prio  = PRIO_HOLD;
    end
  end

  always_comb begin
    previous_light_next = previous_light;
    dark_threshold_next = dark_threshold;
    cmd_speed_next      = cmd_speed;
    remaining_time_next = remaining_time;
    cmd_priority_next   = cmd_priority;
    heading_next        = heading;
    last_turn_next      = last_turn;
    lost_count_next     = lost_count;
    res_next            = '0;

    unique case (ev.action)
      ACT_TICK: begin
        res_next.drive_valid = 1'b1;
        if (time_left) begin
          res_next.brake = 1'b1;
          unique case (heading)
            HEAD_RIGHT: begin
              res_next.right_speed = speed8;
              res_next.left_speed  = neg_half8;
            end
            HEAD_LEFT: begin
              res_next.left_speed  = speed8;
              res_next.right_speed = neg_half8;
            end
            default: begin
              res_next.left_speed  = speed8;
              res_next.right_speed = speed8;
            end
          endcase
          // time is positive here, so one step cannot leave the signed range
          remaining_time_next = remaining_time - $signed({12'd0, tick_step});
        end else if (cmd_priority != PRIO_UNCAL) begin
          cmd_priority_next = PRIO_REST;
        end
      end
      ACT_LIGHT: begin
        previous_light_next = ev.light_sample;
        if (prop_prio > cmd_priority) begin
          cmd_priority_next   = prop_prio;
          cmd_speed_next      = prop_speed;
          remaining_time_next = prop_time;
          heading_next        = prop_head;
          last_turn_next      = prop_turn;
          lost_count_next     = prop_lost;
        end
      end
      ACT_BUTTON: begin
        if (ev.touch) begin
          dark_threshold_next = cal_sum[THRESH_W-1:0];
          cmd_priority_next   = PRIO_REST;
        end
      end
      default: ;
    endcase

    res_next.out_priority = cmd_priority_next;
    res_next.out_heading  = heading_next;
    res_next.out_lost     = lost_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_light <= SENSOR_BITS'(1);
      dark_threshold <= THRESH_RESET;
      cmd_speed      <= '0;
      remaining_time <= '0;
      cmd_priority   <= PRIO_UNCAL;
      heading        <= HEAD_RIGHT;
      last_turn      <= HEAD_RIGHT;
      lost_count     <= '0;
    end else if (advance) begin
      previous_light <= previous_light_next;
      dark_threshold <= dark_threshold_next;
      cmd_speed      <= cmd_speed_next;
      remaining_time <= remaining_time_next;
      cmd_priority   <= cmd_priority_next;
      heading        <= heading_next;
      last_turn      <= last_turn_next;
      lost_count     <= lost_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule
